// File: hdl/tfd_pkg.sv
// Shared types, constants and color conversion functions of the texel format decoder.
`default_nettype none

package tfd_pkg;

    // Palette store geometry
    localparam int PALETTE_ENTRIES = 16384;
    localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
    localparam logic [14:0] PAL_DEPTH = 15'(PALETTE_ENTRIES);

    // Command queue between front and back, depth is a power of two
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Configuration port address width (three 32-bit registers)
    localparam int CFG_AW = 4;

    // Texture format codes
    typedef enum logic [3:0] {
        FMT_I4     = 4'd0,
        FMT_I8     = 4'd1,
        FMT_IA4    = 4'd2,
        FMT_IA8    = 4'd3,
        FMT_RGB565 = 4'd4,
        FMT_RGB5A3 = 4'd5,
        FMT_RGBA8  = 4'd6,
        FMT_C4     = 4'd8,
        FMT_C8     = 4'd9,
        FMT_C14X2  = 4'd10,
        FMT_CMPR   = 4'd14
    } t_tex_fmt;

    // Palette entry formats; the unused code decodes as RGB5A3
    typedef enum logic [1:0] {
        PAL_IA8    = 2'd0,
        PAL_RGB565 = 2'd1,
        PAL_RGB5A3 = 2'd2
    } t_pal_fmt;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_TEX_FMT   = 2'd0,
        REG_PAL_FMT   = 2'd1,
        REG_PAL_COUNT = 2'd2
    } t_reg_idx;

    // Kinds of work handed from front to back
    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_DIRECT = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        logic [3:0]  tex_fmt;
        logic [1:0]  pal_fmt;
        logic [14:0] pal_count;
    } t_cfg;

    // word: RGBA (R in 31:24) for direct results, palette word for writes
    // bad:  error result for decodes, dropped write for palette writes
    typedef struct packed {
        t_cmd_kind         kind;
        logic [PAL_AW-1:0] addr;
        logic [31:0]       word;
        logic              bad;
    } t_cmd;

    function automatic logic [7:0] x4(input logic [3:0] v);
        return {v, v};
    endfunction

    function automatic logic [7:0] x5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [7:0] x6(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

    function automatic logic [31:0] conv565(input logic [15:0] v);
        return {x5(v[15:11]), x6(v[10:5]), x5(v[4:0]), 8'hff};
    endfunction

    function automatic logic [31:0] conv5a3(input logic [15:0] v);
        if (v[15]) begin
            return {x5(v[14:10]), x5(v[9:5]), x5(v[4:0]), 8'hff};
        end
        return {x4(v[11:8]), x4(v[7:4]), x4(v[3:0]), v[14:12], v[14:12], v[14:13]};
    endfunction

    function automatic logic [31:0] conv_ia8(input logic [15:0] v);
        return {v[7:0], v[7:0], v[7:0], v[15:8]};
    endfunction

    // DXT1 color for one selector
    function automatic logic [31:0] cmpr(input logic [31:0] t, input logic [1:0] sel);
        logic [31:0] e0;
        logic [31:0] e1;
        logic [31:0] mix;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [10:0] wsum;
        logic [8:0]  asum;
        logic        gt;
        e0  = conv565(t[31:16]);
        e1  = conv565(t[15:0]);
        gt  = t[31:16] > t[15:0];
        mix = {24'd0, 8'hff};
        for (int k = 0; k < 3; k++) begin
            a = e0[31 - 8 * k -: 8];
            b = e1[31 - 8 * k -: 8];
            if (sel[0]) begin
                wsum = 11'(a) * 11'd3 + 11'(b) * 11'd5;
            end else begin
                wsum = 11'(a) * 11'd5 + 11'(b) * 11'd3;
            end
            asum = 9'(a) + 9'(b);
            mix[31 - 8 * k -: 8] = gt ? wsum[10:3] : asum[8:1];
        end
        unique case (sel)
            2'd0: return e0;
            2'd1: return e1;
            2'd2: return mix;
            2'd3: return gt ? mix : 32'd0;
            default: return 32'd0;
        endcase
    endfunction

endpackage

`default_nettype wire

// File: hdl/tfd_if.sv
// Input and output channel interfaces of the texel format decoder.
`default_nettype none

interface tfd_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [31:0] texel;
    logic [1:0]  cmpr_select;
    logic [13:0] entry_index;
    logic [15:0] entry_value;

    modport source (
        output valid, mode, texel, cmpr_select, entry_index, entry_value,
        input  ready
    );
    modport sink (
        input  valid, mode, texel, cmpr_select, entry_index, entry_value,
        output ready
    );
endinterface

interface tfd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       bad_texel;

    modport source (
        output valid, red, green, blue, alpha, bad_texel,
        input  ready
    );
    modport sink (
        input  valid, red, green, blue, alpha, bad_texel,
        output ready
    );
endinterface

`default_nettype wire

// File: hdl/tfd_front.sv
// Front end: accepts items, decodes direct formats and classifies palette work.
`default_nettype none

module tfd_front (
    tfd_in_if.sink          i_in,
    input  tfd_pkg::t_cfg   i_cfg,
    input  logic            i_q_ready,
    output logic            o_push,
    output tfd_pkg::t_cmd   o_cmd
);

    logic [31:0] t;
    logic [13:0] idx;
    logic        idx_bad;
    logic [31:0] pal_word;

    assign t = i_in.texel;

    // Transfer into the queue whenever it has room
    assign i_in.ready = i_q_ready;
    assign o_push     = i_in.valid && i_q_ready;

    // Palette entry conversion
    always_comb begin
        unique case (i_cfg.pal_fmt)
            tfd_pkg::PAL_IA8:    pal_word = tfd_pkg::conv_ia8(i_in.entry_value);
            tfd_pkg::PAL_RGB565: pal_word = tfd_pkg::conv565(i_in.entry_value);
            default:             pal_word = tfd_pkg::conv5a3(i_in.entry_value);
        endcase
    end

    // Palette index of the paletted formats
    always_comb begin
        unique case (i_cfg.tex_fmt)
            tfd_pkg::FMT_C4: idx = {10'd0, t[3:0]};
            tfd_pkg::FMT_C8: idx = {6'd0, t[7:0]};
            default:         idx = t[13:0];
        endcase
        idx_bad = ({1'b0, idx} >= i_cfg.pal_count) || ({1'b0, idx} >= tfd_pkg::PAL_DEPTH);
    end

    // Classify and decode
    always_comb begin
        o_cmd.kind = tfd_pkg::CMD_DIRECT;
        o_cmd.addr = idx[tfd_pkg::PAL_AW-1:0];
        o_cmd.word = 32'd0;
        o_cmd.bad  = 1'b0;
        if (i_in.mode) begin
            o_cmd.kind = tfd_pkg::CMD_WRITE;
            o_cmd.addr = i_in.entry_index[tfd_pkg::PAL_AW-1:0];
            o_cmd.word = pal_word;
            o_cmd.bad  = {1'b0, i_in.entry_index} >= tfd_pkg::PAL_DEPTH;
        end else begin
            unique case (i_cfg.tex_fmt)
                tfd_pkg::FMT_I4: begin
                    o_cmd.word = {4{tfd_pkg::x4(t[3:0])}};
                end
                tfd_pkg::FMT_I8: begin
                    o_cmd.word = {4{t[7:0]}};
                end
                tfd_pkg::FMT_IA4: begin
                    o_cmd.word = {{3{tfd_pkg::x4(t[3:0])}}, tfd_pkg::x4(t[7:4])};
                end
                tfd_pkg::FMT_IA8: begin
                    o_cmd.word = tfd_pkg::conv_ia8(t[15:0]);
                end
                tfd_pkg::FMT_RGB565: begin
                    o_cmd.word = tfd_pkg::conv565(t[15:0]);
                end
                tfd_pkg::FMT_RGB5A3: begin
                    o_cmd.word = tfd_pkg::conv5a3(t[15:0]);
                end
                tfd_pkg::FMT_RGBA8: begin
                    o_cmd.word = {t[23:16], t[15:8], t[7:0], t[31:24]};
                end
                tfd_pkg::FMT_C4, tfd_pkg::FMT_C8, tfd_pkg::FMT_C14X2: begin
                    o_cmd.kind = tfd_pkg::CMD_LOOKUP;
                    o_cmd.bad  = idx_bad;
                end
                tfd_pkg::FMT_CMPR: begin
                    o_cmd.word = tfd_pkg::cmpr(t, i_in.cmpr_select);
                end
                default: begin
                    o_cmd.bad = 1'b1;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hdl/tfd_queue.sv
// Short command queue that decouples the front end from the back end.
`default_nettype none

module tfd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tfd_pkg::t_cmd i_push_cmd,
    output logic          o_ready,
    output logic          o_valid,
    output tfd_pkg::t_cmd o_head,
    input  logic          i_pop
);

    tfd_pkg::t_cmd               r_slot [tfd_pkg::Q_DEPTH];
    logic [tfd_pkg::Q_AW-1:0]    r_wr_ptr;
    logic [tfd_pkg::Q_AW-1:0]    r_rd_ptr;
    logic [tfd_pkg::Q_CW-1:0]    r_count;
    logic                        pop;

    assign o_ready = r_count != tfd_pkg::Q_CW'(tfd_pkg::Q_DEPTH);
    assign o_valid = r_count != '0;
    assign o_head  = r_slot[r_rd_ptr];
    assign pop     = i_pop && o_valid;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + tfd_pkg::Q_CW'(i_push) - tfd_pkg::Q_CW'(pop);
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != tfd_pkg::Q_CW'(tfd_pkg::Q_DEPTH)))
        else $error("command queue overflow");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= tfd_pkg::Q_CW'(tfd_pkg::Q_DEPTH))
        else $error("command queue count out of range");

endmodule

`default_nettype wire

// File: hdl/tfd_back.sv
// Back end: palette memory writes and lookups, result staging and output register.
`default_nettype none

module tfd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  tfd_pkg::t_cmd i_head,
    output logic          o_pop,
    tfd_out_if.source     o_out
);

    logic [31:0] r_mem [tfd_pkg::PALETTE_ENTRIES];
    logic [31:0] r_rdata;

    logic        r_s1_valid;
    logic        r_s1_lookup;
    logic        r_s1_bad;
    logic [31:0] r_s1_word;

    logic        r_o_valid;
    logic        r_o_bad;
    logic [31:0] r_o_word;
    logic [31:0] n_o_word;

    logic        o_load_ok;
    logic        s1_adv;

    // Handshake between the stages
    assign o_load_ok = !r_o_valid || o_out.ready;
    assign s1_adv    = r_s1_valid && o_load_ok;
    assign o_pop     = i_q_valid && (!r_s1_valid || s1_adv);

    // Palette memory: writes and reads go in queue order, one a cycle when not stalled
    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.kind == tfd_pkg::CMD_WRITE && !i_head.bad) begin
            r_mem[i_head.addr] <= i_head.word;
        end
        if (o_pop && i_head.kind == tfd_pkg::CMD_LOOKUP) begin
            r_rdata <= r_mem[i_head.addr];
        end
    end

    // Stage 1: waits for the memory read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_pop) begin
            r_s1_valid <= i_head.kind != tfd_pkg::CMD_WRITE;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_lookup <= i_head.kind == tfd_pkg::CMD_LOOKUP;
            r_s1_bad    <= i_head.bad;
            r_s1_word   <= i_head.word;
        end
    end

    // Final color select; an error result is all zero
    always_comb begin
        if (r_s1_bad) begin
            n_o_word = 32'd0;
        end else if (r_s1_lookup) begin
            n_o_word = r_rdata;
        end else begin
            n_o_word = r_s1_word;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_adv) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_o_word <= n_o_word;
            r_o_bad  <= r_s1_bad;
        end
    end

    assign o_out.valid     = r_o_valid;
    assign o_out.red       = r_o_word[31:24];
    assign o_out.green     = r_o_word[23:16];
    assign o_out.blue      = r_o_word[15:8];
    assign o_out.alpha     = r_o_word[7:0];
    assign o_out.bad_texel = r_o_bad;

    a_lookup_staged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_head.kind == tfd_pkg::CMD_LOOKUP |=> r_s1_valid && r_s1_lookup)
        else $error("palette lookup not staged after pop");

    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_head.kind == tfd_pkg::CMD_WRITE |=> !r_s1_valid)
        else $error("palette write produced a result");

    a_bad_is_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.bad_texel |-> r_o_word == 32'd0)
        else $error("error result carries nonzero color");

endmodule

`default_nettype wire

// File: hdl/texel_format_decoder.sv
// Top level of the texel format decoder: configuration registers and the front/queue/back chain.
//
// Decodes one texel per clock, unless the output stalls, into 8-bit RGBA under the configured
// texture format and gives one result per decode item; a palette-write item gives no result
// and stores its converted entry. Items flow from the input through a decode front end, a
// two-entry command queue and a back end that holds the 16384 x 32-bit palette memory (one
// write and one registered read port), so the sustained rate is one item per cycle while the
// output is ready. Each result passes the queue slot, the stage 1 register and the output
// register. Palette writes and lookups reach the memory in arrival order, so a lookup right
// after a write sees the new entry. The palette memory is not cleared after reset: a lookup of
// an entry never written returns undefined color. Configuration registers sit on an APB-style
// port at byte addresses 0 (texture format), 4 (palette format) and 8 (palette size) and are
// to be written only while the block is idle; the block itself does not enforce this.
`default_nettype none

module texel_format_decoder (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    tfd_in_if.sink                     i_in,
    tfd_out_if.source                  o_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tfd_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic [3:0]    r_tex_fmt;
    logic [1:0]    r_pal_fmt;
    logic [14:0]   r_pal_count;
    tfd_pkg::t_cfg cfg;
    logic          cfg_wr;

    logic          q_push;
    logic          q_ready;
    logic          q_valid;
    logic          q_pop;
    tfd_pkg::t_cmd push_cmd;
    tfd_pkg::t_cmd head_cmd;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_fmt   <= '0;
            r_pal_fmt   <= '0;
            r_pal_count <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                tfd_pkg::REG_TEX_FMT:   r_tex_fmt   <= pwdata[3:0];
                tfd_pkg::REG_PAL_FMT:   r_pal_fmt   <= pwdata[1:0];
                tfd_pkg::REG_PAL_COUNT: r_pal_count <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            tfd_pkg::REG_TEX_FMT:   prdata = {28'd0, r_tex_fmt};
            tfd_pkg::REG_PAL_FMT:   prdata = {30'd0, r_pal_fmt};
            tfd_pkg::REG_PAL_COUNT: prdata = {17'd0, r_pal_count};
            default:                prdata = 32'd0;
        endcase
    end

    assign cfg.tex_fmt   = r_tex_fmt;
    assign cfg.pal_fmt   = r_pal_fmt;
    assign cfg.pal_count = r_pal_count;

    // Decode front end
    tfd_front u_front (
        .i_in      (i_in),
        .i_cfg     (cfg),
        .i_q_ready (q_ready),
        .o_push    (q_push),
        .o_cmd     (push_cmd)
    );

    // Command queue
    tfd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_cmd (push_cmd),
        .o_ready    (q_ready),
        .o_valid    (q_valid),
        .o_head     (head_cmd),
        .i_pop      (q_pop)
    );

    // Palette and output back end
    tfd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_head    (head_cmd),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire
